[sv/tlsu_pkg.sv]
package tlsu_pkg;

  localparam int unsigned PendingDepthDefault = 9;

  typedef enum logic [1:0] {
    REQ_EXEC   = 2'd0,
    REQ_RETURN = 2'd1,
    REQ_SET    = 2'd2,
    REQ_BAD    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_BUSY   = 2'd1,
    ERR_STRAY  = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    K_WORD  = 3'd0,
    K_BYTE  = 3'd1,
    K_HALF  = 3'd2,
    K_SBYTE = 3'd3,
    K_SHALF = 3'd4,
    K_POPPC = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    SZ_BYTE = 2'd0,
    SZ_HALF = 2'd1,
    SZ_WORD = 2'd2
  } size_t_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MULTI,
    ST_TAIL,
    ST_RET_WB
  } state_t;

  // operation chosen by the decoder
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ERR_BUSY,
    OP_ERR_STRAY,
    OP_REG,
    OP_CMP,
    OP_BX,
    OP_STORE,
    OP_LOAD,
    OP_MULTI,
    OP_RETURN
  } op_t;

  typedef struct packed {
    logic       latch;
    logic       decode;
    logic       emit_single;
    logic       emit_multi;
    logic       emit_tail;
    logic       emit_wb;
  } ctl_cmd_t;

  typedef struct packed {
    op_t        op;
    logic       list_empty;
    logic       list_last;
    logic       wb_after_ret;
  } ctl_sts_t;

endpackage

[sv/thumb_load_store_unit.sv]
// A request is latched at start, then decoded; each result is registered onto the ports.
// After the first result, one result per cycle.
// Load/store multiple: one bus request per cycle, then the writeback of the base register.
// A new transaction is not taken until the previous one has put its last result on the
// ports; a return that releases a deferred writeback ends with that writeback.
// Results cannot be stalled; out_strobe marks each for one cycle.
// rst_n is synchronous: registers, flags and queue clear, T bit sets.
module thumb_load_store_unit
  import tlsu_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = PendingDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_instruction,
  input  logic [31:0] in_data_in,
  input  logic [3:0]  in_reg_select,
  output logic        out_strobe,
  output logic        out_bus_valid,
  output logic        out_bus_write,
  output logic [31:0] out_bus_address,
  output logic [1:0]  out_bus_size,
  output logic [31:0] out_store_data,
  output logic        out_reg_write,
  output logic [3:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic [3:0]  out_flags_now,
  output logic        out_thumb_state,
  output logic        out_last,
  output logic [1:0]  out_error
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     busy_c, out_strobe_c;

  tlsu_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy(busy_c), .sts, .cmd
  );

  tlsu_dp #(.PENDING_DEPTH(PENDING_DEPTH)) u_dp (
    .clk, .rst_n, .in_req_type, .in_instruction, .in_data_in, .in_reg_select,
    .cmd, .sts, .out_strobe(out_strobe_c), .out_bus_valid, .out_bus_write,
    .out_bus_address, .out_bus_size, .out_store_data, .out_reg_write,
    .out_reg_index, .out_reg_value, .out_flags_now, .out_thumb_state,
    .out_last, .out_error
  );

  // hold off new work while a result that is not the final one is still on the ports
  assign busy = busy_c | (out_strobe_c & ~out_last);
  assign out_strobe = out_strobe_c;

endmodule

[sv/tlsu_ctrl.sv]
module tlsu_ctrl
  import tlsu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_DECODE;
      ST_DECODE: begin
        if (sts.op == OP_MULTI) begin
          state_nxt = sts.list_empty ? ST_TAIL : ST_MULTI;
        end else if (sts.op == OP_RETURN && sts.wb_after_ret) begin
          state_nxt = ST_RET_WB;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MULTI:  if (sts.list_last) state_nxt = ST_TAIL;
      ST_TAIL:   state_nxt = ST_IDLE;
      ST_RET_WB: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:   cmd.latch = start;
      ST_DECODE: begin
        cmd.decode = 1'b1;
        cmd.emit_single = (sts.op != OP_MULTI);
      end
      ST_MULTI:  cmd.emit_multi = 1'b1;
      ST_TAIL:   cmd.emit_tail = 1'b1;
      ST_RET_WB: cmd.emit_wb = 1'b1;
      default:   cmd = '0;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[sv/tlsu_dp.sv]
module tlsu_dp
  import tlsu_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = PendingDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_instruction,
  input  logic [31:0] in_data_in,
  input  logic [3:0]  in_reg_select,
  input  ctl_cmd_t    cmd,
  output ctl_sts_t    sts,
  output logic        out_strobe,
  output logic        out_bus_valid,
  output logic        out_bus_write,
  output logic [31:0] out_bus_address,
  output logic [1:0]  out_bus_size,
  output logic [31:0] out_store_data,
  output logic        out_reg_write,
  output logic [3:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic [3:0]  out_flags_now,
  output logic        out_thumb_state,
  output logic        out_last,
  output logic [1:0]  out_error
);

  localparam int unsigned PW = $clog2(PENDING_DEPTH);
  localparam int unsigned CW = $clog2(PENDING_DEPTH + 1);

  logic [31:0] rf_r [16];
  logic [3:0]  flags_r;
  logic        tbit_r;
  logic [6:0]  pq_mem [PENDING_DEPTH];
  logic [CW-1:0] pcnt_r;
  logic [PW-1:0] phead_r;
  logic        wb_armed_r;
  logic [3:0]  wb_tgt_r;
  logic [31:0] wb_val_r;

  logic [1:0]  req_r;
  logic [15:0] op_r;
  logic [31:0] data_r;
  logic [3:0]  sel_r;

  // multi-transfer iteration
  logic [8:0]  list_r;
  logic [31:0] maddr_r;
  logic        mload_r;
  logic [3:0]  wbt_r;
  logic [31:0] wbv_r;

  logic        o_strobe_r, o_bv_r, o_bw_r, o_rw_r, o_last_r;
  logic [31:0] o_ba_r, o_sd_r, o_rv_r;
  logic [1:0]  o_bs_r, o_err_r;
  logic [3:0]  o_ri_r;

  // decode
  op_t         op;
  logic        d_bw;
  logic [31:0] d_addr, d_sd, d_rv;
  logic [1:0]  d_bs;
  logic [3:0]  d_ri, d_flags;
  logic        d_tbit;
  kind_t       d_kind;
  logic [2:0]  rd, rb, rh, ro;
  logic [4:0]  imm5;
  logic [8:0]  d_list;
  logic [31:0] d_maddr, d_wbv;
  logic [3:0]  d_wbt, d_cnt;
  logic        d_mload;
  logic [3:0]  hrd, hrm;
  logic [31:0] hmv, hdv, hres;
  logic [6:0]  pe;
  logic [31:0] rv_ret;
  logic [3:0]  list_idx;
  logic [8:0]  list_low;
  logic [31:0] m_sd;
  logic [PW-1:0] tail_slot;
  logic [PW:0] tail_sum;

  function automatic logic [3:0] popc9(input logic [8:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) n = n + {3'd0, v[i]};
    return n;
  endfunction

  assign rd   = op_r[2:0];
  assign rb   = op_r[5:3];
  assign ro   = op_r[8:6];
  assign rh   = op_r[10:8];
  assign imm5 = op_r[10:6];
  assign hrd  = {op_r[7], op_r[2:0]};
  assign hrm  = op_r[6] ? op_r[6:3] : {1'b0, op_r[5:3]};
  assign hdv  = rf_r[hrd];
  assign hmv  = (hrd == 4'd15) ? rf_r[hrm] + 32'd2 : rf_r[hrm];
  assign hres = hdv - hmv;

  always_comb begin
    op = OP_NONE; d_bw = 1'b0; d_addr = '0; d_bs = SZ_WORD; d_sd = '0;
    d_ri = '0; d_rv = '0; d_kind = K_WORD; d_flags = flags_r; d_tbit = tbit_r;
    d_list = '0; d_maddr = '0; d_wbt = '0; d_wbv = '0; d_mload = 1'b0;
    d_cnt = '0;
    case (req_r)
      REQ_EXEC: begin
        if (pcnt_r != '0) begin
          op = OP_ERR_BUSY;
        end else if (op_r[15:10] == 6'h11) begin
          case (op_r[9:8])
            2'd0: begin op = OP_REG; d_ri = hrd; d_rv = hdv + hmv; end
            2'd1: begin
              op = OP_CMP;
              d_flags = {hres[31], hres == '0, hdv >= hmv,
                         ((hdv ^ hmv) & (hdv ^ hres)) >> 31 != '0};
            end
            2'd2: begin op = OP_REG; d_ri = hrd; d_rv = hmv; end
            default: begin
              op = OP_BX; d_tbit = hmv[0]; d_ri = 4'd15;
              d_rv = (hmv & 32'hFFFF_FFFE) + (hmv[0] ? 32'd2 : 32'd6);
            end
          endcase
        end else if (op_r[15:11] == 5'h09) begin
          op = OP_LOAD; d_ri = {1'b0, rh}; d_bs = SZ_WORD;
          d_addr = (rf_r[15] & 32'hFFFF_FFFC) + {22'd0, op_r[7:0], 2'b00};
        end else if (op_r[15:12] == 4'h5) begin
          d_addr = rf_r[rb] + rf_r[ro]; d_sd = rf_r[rd]; d_ri = {1'b0, rd};
          case ({op_r[9], op_r[11:10]})
            3'b000: begin op = OP_STORE; d_bs = SZ_WORD; end
            3'b001: begin op = OP_STORE; d_bs = SZ_BYTE; end
            3'b010: begin op = OP_LOAD; d_bs = SZ_WORD; d_kind = K_WORD; end
            3'b011: begin op = OP_LOAD; d_bs = SZ_BYTE; d_kind = K_BYTE; end
            3'b100: begin op = OP_STORE; d_bs = SZ_HALF; end
            3'b101: begin op = OP_LOAD; d_bs = SZ_BYTE; d_kind = K_SBYTE; end
            3'b110: begin op = OP_LOAD; d_bs = SZ_HALF; d_kind = K_HALF; end
            default: begin op = OP_LOAD; d_bs = SZ_HALF; d_kind = K_SHALF; end
          endcase
        end else if (op_r[15:13] == 3'h3) begin
          d_sd = rf_r[rd]; d_ri = {1'b0, rd};
          case (op_r[12:11])
            2'd0: begin op = OP_STORE; d_bs = SZ_WORD;
              d_addr = rf_r[rb] + {25'd0, imm5, 2'b00}; end
            2'd1: begin op = OP_LOAD; d_bs = SZ_WORD;
              d_addr = rf_r[rb] + {25'd0, imm5, 2'b00}; end
            2'd2: begin op = OP_STORE; d_bs = SZ_BYTE;
              d_addr = rf_r[rb] + {27'd0, imm5}; end
            default: begin op = OP_LOAD; d_bs = SZ_BYTE; d_kind = K_BYTE;
              d_addr = rf_r[rb] + {27'd0, imm5}; end
          endcase
        end else if (op_r[15:12] == 4'h8) begin
          d_addr = rf_r[rb] + {26'd0, imm5, 1'b0}; d_bs = SZ_HALF;
          d_sd = rf_r[rd]; d_ri = {1'b0, rd}; d_kind = K_HALF;
          op = op_r[11] ? OP_LOAD : OP_STORE;
        end else if (op_r[15:12] == 4'h9) begin
          d_addr = rf_r[13] + {22'd0, op_r[7:0], 2'b00}; d_bs = SZ_WORD;
          d_sd = rf_r[rh]; d_ri = {1'b0, rh};
          op = op_r[11] ? OP_LOAD : OP_STORE;
        end else if (op_r[15:12] == 4'hA) begin
          op = OP_REG; d_ri = {1'b0, rh};
          d_rv = (op_r[11] ? rf_r[13] : (rf_r[15] & 32'hFFFF_FFFC))
                 + {22'd0, op_r[7:0], 2'b00};
        end else if (op_r[15:8] == 8'hB0) begin
          op = OP_REG; d_ri = 4'd13;
          d_rv = op_r[7] ? rf_r[13] - {23'd0, op_r[6:0], 2'b00}
                         : rf_r[13] + {23'd0, op_r[6:0], 2'b00};
        end else if ((op_r & 16'hF600) == 16'hB400) begin
          op = OP_MULTI; d_list = op_r[8:0]; d_cnt = popc9(op_r[8:0]);
          d_mload = op_r[11]; d_wbt = 4'd13;
          if (op_r[11]) begin
            d_maddr = rf_r[13];
            d_wbv = rf_r[13] + {26'd0, d_cnt, 2'b00};
          end else begin
            d_maddr = rf_r[13] - {26'd0, d_cnt, 2'b00};
            d_wbv = d_maddr;
          end
        end else if (op_r[15:12] == 4'hC) begin
          op = OP_MULTI; d_list = {1'b0, op_r[7:0]};
          d_cnt = popc9({1'b0, op_r[7:0]});
          d_mload = op_r[11]; d_wbt = {1'b0, rh}; d_maddr = rf_r[rh];
          d_wbv = rf_r[rh] + {26'd0, d_cnt, 2'b00};
        end else begin
          op = OP_ERR_BUSY;
        end
      end
      REQ_RETURN: op = (pcnt_r == '0) ? OP_ERR_STRAY : OP_RETURN;
      REQ_SET: begin op = OP_REG; d_ri = sel_r; d_rv = data_r; end
      default: op = OP_ERR_BUSY;
    endcase
  end

  assign pe = pq_mem[phead_r];
  always_comb begin
    case (kind_t'(pe[6:4]))
      K_BYTE:  rv_ret = {24'd0, data_r[7:0]};
      K_HALF:  rv_ret = {16'd0, data_r[15:0]};
      K_SBYTE: rv_ret = {{24{data_r[7]}}, data_r[7:0]};
      K_SHALF: rv_ret = {{16{data_r[15]}}, data_r[15:0]};
      K_POPPC: rv_ret = (data_r & 32'hFFFF_FFFE) + 32'd2;
      default: rv_ret = data_r;
    endcase
  end

  // lowest set bit of the remaining list
  always_comb begin
    list_idx = 4'd8;
    for (int i = 7; i >= 0; i--) if (list_r[i]) list_idx = 4'(i);
  end
  assign list_low = list_r & ~(list_r - 9'd1);
  assign m_sd = (list_idx == 4'd8) ? rf_r[14] : rf_r[list_idx[2:0]];

  assign sts.op = op;
  assign sts.list_empty = (d_list == '0);
  assign sts.list_last = ((list_r & ~list_low) == '0);
  assign sts.wb_after_ret = (pcnt_r == CW'(1)) && wb_armed_r;

  assign tail_sum = {1'b0, phead_r} + PW'(pcnt_r);
  assign tail_slot = (tail_sum >= (PW+1)'(PENDING_DEPTH)) ?
                     PW'(tail_sum - (PW+1)'(PENDING_DEPTH)) : tail_sum[PW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req_type; op_r <= in_instruction;
      data_r <= in_data_in; sel_r <= in_reg_select;
    end
    if ((cmd.decode && op == OP_LOAD && pcnt_r < CW'(PENDING_DEPTH)) ||
        (cmd.emit_multi && mload_r && pcnt_r < CW'(PENDING_DEPTH))) begin
      pq_mem[tail_slot] <= cmd.decode ? {d_kind, d_ri}
        : ((list_idx == 4'd8) ? {K_POPPC, 4'd15} : {K_WORD, list_idx});
    end
    if (cmd.decode) begin
      list_r <= d_list; maddr_r <= d_maddr; mload_r <= d_mload;
      wbt_r <= d_wbt; wbv_r <= d_wbv;
    end else if (cmd.emit_multi) begin
      list_r <= list_r & ~list_low;
      maddr_r <= maddr_r + 32'd4;
    end
    o_ba_r <= '0; o_sd_r <= '0; o_rv_r <= '0; o_ri_r <= '0; o_bs_r <= '0;
    if (cmd.decode) begin
      if (op == OP_STORE || op == OP_LOAD) begin
        o_ba_r <= d_addr; o_bs_r <= d_bs;
      end
      if (op == OP_STORE) begin
        o_sd_r <= (d_bs == SZ_BYTE) ? {24'd0, d_sd[7:0]} :
                  (d_bs == SZ_HALF) ? {16'd0, d_sd[15:0]} : d_sd;
      end
      if (op == OP_REG || op == OP_BX) begin o_ri_r <= d_ri; o_rv_r <= d_rv; end
      if (op == OP_RETURN) begin o_ri_r <= pe[3:0]; o_rv_r <= rv_ret; end
    end else if (cmd.emit_multi) begin
      o_ba_r <= maddr_r; o_bs_r <= SZ_WORD;
      if (!mload_r) o_sd_r <= m_sd;
    end else if (cmd.emit_tail) begin
      if (pcnt_r == '0) begin o_ri_r <= wbt_r; o_rv_r <= wbv_r; end
    end else if (cmd.emit_wb) begin
      o_ri_r <= wb_tgt_r; o_rv_r <= wb_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) rf_r[i] <= '0;
      flags_r <= '0; tbit_r <= 1'b1; pcnt_r <= '0; phead_r <= '0;
      wb_armed_r <= 1'b0; wb_tgt_r <= '0; wb_val_r <= '0;
      o_strobe_r <= 1'b0; o_bv_r <= 1'b0; o_bw_r <= 1'b0; o_rw_r <= 1'b0;
      o_last_r <= 1'b0; o_err_r <= ERR_OK;
    end else begin
      o_strobe_r <= cmd.emit_single | cmd.emit_multi |
                    (cmd.emit_tail & (pcnt_r == '0)) | cmd.emit_wb;
      o_bv_r <= 1'b0; o_bw_r <= 1'b0; o_rw_r <= 1'b0; o_err_r <= ERR_OK;
      o_last_r <= 1'b0;
      if (cmd.decode) begin
        case (op)
          OP_ERR_BUSY:  o_err_r <= ERR_BUSY;
          OP_ERR_STRAY: o_err_r <= ERR_STRAY;
          OP_CMP:       flags_r <= d_flags;
          OP_REG: begin rf_r[d_ri] <= d_rv; o_rw_r <= 1'b1; end
          OP_BX: begin rf_r[d_ri] <= d_rv; o_rw_r <= 1'b1; tbit_r <= d_tbit; end
          OP_STORE: begin o_bv_r <= 1'b1; o_bw_r <= 1'b1; end
          OP_LOAD: begin
            o_bv_r <= 1'b1;
            if (pcnt_r < CW'(PENDING_DEPTH)) pcnt_r <= pcnt_r + CW'(1);
          end
          OP_RETURN: begin
            rf_r[pe[3:0]] <= rv_ret; o_rw_r <= 1'b1;
            phead_r <= (phead_r == PW'(PENDING_DEPTH - 1)) ? '0 : phead_r + PW'(1);
            pcnt_r <= pcnt_r - CW'(1);
          end
          default: ;
        endcase
        o_last_r <= !(op == OP_MULTI || (op == OP_RETURN && sts.wb_after_ret));
      end
      if (cmd.emit_multi) begin
        o_bv_r <= 1'b1; o_bw_r <= !mload_r;
        if (mload_r && pcnt_r < CW'(PENDING_DEPTH)) pcnt_r <= pcnt_r + CW'(1);
        // a multi-load always defers its writeback, so its last request ends it
        o_last_r <= sts.list_last && mload_r;
      end
      if (cmd.emit_tail) begin
        if (pcnt_r == '0) begin
          rf_r[wbt_r] <= wbv_r; o_rw_r <= 1'b1; o_last_r <= 1'b1;
        end else begin
          wb_armed_r <= 1'b1; wb_tgt_r <= wbt_r; wb_val_r <= wbv_r;
        end
      end
      if (cmd.emit_wb) begin
        wb_armed_r <= 1'b0; rf_r[wb_tgt_r] <= wb_val_r;
        o_rw_r <= 1'b1; o_last_r <= 1'b1;
      end
    end
  end

  assign out_strobe      = o_strobe_r;
  assign out_bus_valid   = o_bv_r;
  assign out_bus_write   = o_bw_r;
  assign out_bus_address = o_ba_r;
  assign out_bus_size    = o_bs_r;
  assign out_store_data  = o_sd_r;
  assign out_reg_write   = o_rw_r;
  assign out_reg_index   = o_ri_r;
  assign out_reg_value   = o_rv_r;
  assign out_flags_now   = flags_r;
  assign out_thumb_state = tbit_r;
  assign out_last        = o_last_r;
  assign out_error       = o_err_r;

endmodule

[sv/tlsu_checker.sv]
module tlsu_checker
  import tlsu_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_bus_valid,
  input logic       out_bus_write,
  input logic       out_reg_write,
  input logic       out_last,
  input logic [1:0] out_error
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised");

  a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_error != ERR_OK |-> out_last && !out_bus_valid && !out_reg_write)
    else $error("error result carries payload");

  a_bus_xor_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_bus_valid && out_reg_write)) else $error("bus and reg together");

  a_write_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus_write |-> out_bus_valid) else $error("write without request");

endmodule

bind thumb_load_store_unit tlsu_checker u_tlsu_checker (
  .clk, .rst_n, .start, .busy, .out_strobe, .out_bus_valid, .out_bus_write,
  .out_reg_write, .out_last, .out_error
);

[tb/thumb_load_store_unit_test.sv]
module thumb_load_store_unit_test
  import tlsu_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        bus_valid;
    logic        bus_write;
    logic [31:0] bus_address;
    logic [1:0]  bus_size;
    logic [31:0] store_data;
    logic        reg_write;
    logic [3:0]  reg_index;
    logic [31:0] reg_value;
    logic [3:0]  flags_now;
    logic        thumb_state;
    logic        last;
    logic [1:0]  error;
  } lsu_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type = '0;
  logic [15:0] in_instruction = '0;
  logic [31:0] in_data_in = '0;
  logic [3:0]  in_reg_select = '0;
  logic        out_strobe;
  logic        out_bus_valid;
  logic        out_bus_write;
  logic [31:0] out_bus_address;
  logic [1:0]  out_bus_size;
  logic [31:0] out_store_data;
  logic        out_reg_write;
  logic [3:0]  out_reg_index;
  logic [31:0] out_reg_value;
  logic [3:0]  out_flags_now;
  logic        out_thumb_state;
  logic        out_last;
  logic [1:0]  out_error;

  thumb_load_store_unit i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow architectural state
  logic [31:0] gpr[16];
  logic [3:0]  nzcv;
  logic        tbit;
  logic [6:0]  load_ring[PendingDepthDefault];
  int unsigned ring_cnt, ring_head;
  logic        wb_armed;
  logic [3:0]  wb_reg;
  logic [31:0] wb_val;

  lsu_result_t step_res[$];
  lsu_result_t expected_q[$];
  int errors = 0;
  int unsigned idle_pct = 0;
  int unsigned n_items = 0;

  function automatic lsu_result_t blank();
    lsu_result_t r;
    r = '0;
    return r;
  endfunction

  function automatic void emit_err(logic [1:0] code);
    lsu_result_t r;
    r = blank();
    r.error = code;
    step_res.push_back(r);
  endfunction

  function automatic void emit_bus(logic wr, logic [31:0] addr, logic [1:0] sz,
                                   logic [31:0] data);
    lsu_result_t r;
    r = blank();
    r.bus_valid = 1'b1;
    r.bus_write = wr;
    r.bus_address = addr;
    r.bus_size = sz;
    if (wr) r.store_data = sz == SZ_BYTE ? {24'd0, data[7:0]} :
                           sz == SZ_HALF ? {16'd0, data[15:0]} : data;
    step_res.push_back(r);
  endfunction

  function automatic void emit_reg(logic [3:0] idx, logic [31:0] v);
    lsu_result_t r;
    r = blank();
    gpr[idx] = v;
    r.reg_write = 1'b1;
    r.reg_index = idx;
    r.reg_value = v;
    step_res.push_back(r);
  endfunction

  function automatic void queue_load(logic [31:0] addr, logic [1:0] sz, logic [3:0] dst,
                                     kind_t k);
    emit_bus(1'b0, addr, sz, 32'd0);
    if (ring_cnt < PendingDepthDefault) begin
      load_ring[(ring_head + ring_cnt) % PendingDepthDefault] = {k, dst};
      ring_cnt++;
    end
  endfunction

  function automatic void defer_writeback(logic [3:0] tgt, logic [31:0] v);
    if (ring_cnt == 0) emit_reg(tgt, v);
    else begin
      wb_armed = 1'b1;
      wb_reg = tgt;
      wb_val = v;
    end
  endfunction

  function automatic int unsigned ones(logic [8:0] v);
    int unsigned n = 0;
    for (int i = 0; i < 9; i++) n += v[i];
    return n;
  endfunction

  function automatic void do_hireg(logic [15:0] op);
    logic [3:0]  rd, rm;
    logic [31:0] mv, dv, res;
    logic [3:0]  f;
    rd = {op[7], op[2:0]};
    rm = op[6] ? op[6:3] : {1'b0, op[5:3]};
    mv = gpr[rm];
    dv = gpr[rd];
    if (rd == 4'd15) mv += 32'd2;
    case (op[9:8])
      2'd0: emit_reg(rd, dv + mv);
      2'd1: begin
        res = dv - mv;
        f = {res[31], res == 32'd0, dv >= mv, ((dv ^ mv) & (dv ^ res)) >> 31 != 0};
        nzcv = f;
        step_res.push_back(blank());
      end
      2'd2: emit_reg(rd, mv);
      default: begin
        tbit = mv[0];
        emit_reg(4'd15, {mv[31:1], 1'b0} + (tbit ? 32'd2 : 32'd6));
      end
    endcase
  endfunction

  function automatic void do_insn(logic [15:0] op);
    logic [2:0]  rd, rb, rh;
    logic [4:0]  imm5;
    logic [31:0] addr, base, sp;
    int unsigned n;
    rd = op[2:0];
    rb = op[5:3];
    rh = op[10:8];
    imm5 = op[10:6];
    if (op[15:10] == 6'h11) do_hireg(op);
    else if (op[15:11] == 5'h09)
      queue_load({gpr[15][31:2], 2'b00} + op[7:0] * 4, SZ_WORD, rh, K_WORD);
    else if (op[15:12] == 4'h5) begin
      addr = gpr[rb] + gpr[op[8:6]];
      if (op[9]) begin
        case (op[11:10])
          2'd0: emit_bus(1'b1, addr, SZ_HALF, gpr[rd]);
          2'd1: queue_load(addr, SZ_BYTE, rd, K_SBYTE);
          2'd2: queue_load(addr, SZ_HALF, rd, K_HALF);
          default: queue_load(addr, SZ_HALF, rd, K_SHALF);
        endcase
      end else begin
        case (op[11:10])
          2'd0: emit_bus(1'b1, addr, SZ_WORD, gpr[rd]);
          2'd1: emit_bus(1'b1, addr, SZ_BYTE, gpr[rd]);
          2'd2: queue_load(addr, SZ_WORD, rd, K_WORD);
          default: queue_load(addr, SZ_BYTE, rd, K_BYTE);
        endcase
      end
    end else if (op[15:13] == 3'h3) begin
      base = gpr[rb];
      case (op[12:11])
        2'd0: emit_bus(1'b1, base + imm5 * 4, SZ_WORD, gpr[rd]);
        2'd1: queue_load(base + imm5 * 4, SZ_WORD, rd, K_WORD);
        2'd2: emit_bus(1'b1, base + imm5, SZ_BYTE, gpr[rd]);
        default: queue_load(base + imm5, SZ_BYTE, rd, K_BYTE);
      endcase
    end else if (op[15:12] == 4'h8) begin
      addr = gpr[rb] + (imm5 << 1);
      if (op[11]) queue_load(addr, SZ_HALF, rd, K_HALF);
      else emit_bus(1'b1, addr, SZ_HALF, gpr[rd]);
    end else if (op[15:12] == 4'h9) begin
      addr = gpr[13] + op[7:0] * 4;
      if (op[11]) queue_load(addr, SZ_WORD, rh, K_WORD);
      else emit_bus(1'b1, addr, SZ_WORD, gpr[rh]);
    end else if (op[15:12] == 4'hA) begin
      if (op[11]) emit_reg(rh, gpr[13] + (op[7:0] << 2));
      else emit_reg(rh, {gpr[15][31:2], 2'b00} + (op[7:0] << 2));
    end else if (op[15:8] == 8'hB0) begin
      if (op[7]) emit_reg(4'd13, gpr[13] - (op[6:0] << 2));
      else emit_reg(4'd13, gpr[13] + (op[6:0] << 2));
    end else if ((op & 16'hF600) == 16'hB400) begin
      sp = gpr[13];
      n = ones(op[8:0]);
      if (op[11]) begin
        addr = sp;
        for (int i = 0; i < 8; i++)
          if (op[i]) begin
            queue_load(addr, SZ_WORD, i, K_WORD);
            addr += 4;
          end
        if (op[8]) queue_load(addr, SZ_WORD, 4'd15, K_POPPC);
        defer_writeback(4'd13, sp + n * 4);
      end else begin
        addr = sp - n * 4;
        for (int i = 0; i < 8; i++)
          if (op[i]) begin
            emit_bus(1'b1, addr, SZ_WORD, gpr[i]);
            addr += 4;
          end
        if (op[8]) emit_bus(1'b1, addr, SZ_WORD, gpr[14]);
        emit_reg(4'd13, sp - n * 4);
      end
    end else if (op[15:12] == 4'hC) begin
      base = gpr[rh];
      addr = base;
      for (int i = 0; i < 8; i++)
        if (op[i]) begin
          if (op[11]) queue_load(addr, SZ_WORD, i, K_WORD);
          else emit_bus(1'b1, addr, SZ_WORD, gpr[i]);
          addr += 4;
        end
      defer_writeback(rh, base + ones({1'b0, op[7:0]}) * 4);
    end else emit_err(ERR_BUSY);
  endfunction

  function automatic void do_return(logic [31:0] d);
    logic [6:0]  e;
    logic [31:0] v;
    if (ring_cnt == 0) begin
      emit_err(ERR_STRAY);
      return;
    end
    e = load_ring[ring_head];
    ring_head = (ring_head + 1) % PendingDepthDefault;
    ring_cnt--;
    case (kind_t'(e[6:4]))
      K_BYTE:  v = {24'd0, d[7:0]};
      K_HALF:  v = {16'd0, d[15:0]};
      K_SBYTE: v = {{24{d[7]}}, d[7:0]};
      K_SHALF: v = {{16{d[15]}}, d[15:0]};
      K_POPPC: v = {d[31:1], 1'b0} + 32'd2;
      default: v = d;
    endcase
    emit_reg(e[3:0], v);
    if (ring_cnt == 0 && wb_armed) begin
      wb_armed = 1'b0;
      emit_reg(wb_reg, wb_val);
    end
  endfunction

  function automatic void predict_lsu(logic [1:0] rq, logic [15:0] op, logic [31:0] d,
                                      logic [3:0] sel);
    lsu_result_t r;
    step_res.delete();
    case (rq)
      REQ_EXEC:   if (ring_cnt != 0) emit_err(ERR_BUSY); else do_insn(op);
      REQ_RETURN: do_return(d);
      REQ_SET:    emit_reg(sel, d);
      default:    emit_err(ERR_BUSY);
    endcase
    if (step_res.size() == 0) step_res.push_back(blank());
    if (step_res.size() > 10) step_res = step_res[0:9];
    foreach (step_res[k]) begin
      r = step_res[k];
      r.flags_now = nzcv;
      r.thumb_state = tbit;
      r.last = (k == step_res.size() - 1);
      expected_q.push_back(r);
    end
  endfunction

  task automatic send_item(logic [1:0] rq, logic [15:0] op, logic [31:0] d, logic [3:0] sel);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= rq;
    in_instruction <= op;
    in_data_in <= d;
    in_reg_select <= sel;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
    predict_lsu(rq, op, d, sel);
  endtask

  task automatic exec_op(logic [15:0] op);
    send_item(REQ_EXEC, op, $urandom, $urandom);
  endtask

  task automatic set_reg(logic [3:0] r, logic [31:0] v);
    send_item(REQ_SET, $urandom, v, r);
  endtask

  task automatic drain_loads();
    while (ring_cnt != 0) send_item(REQ_RETURN, $urandom, $urandom, $urandom);
  endtask

  always @(posedge clk) begin
    lsu_result_t got, exp;
    if (rst_n && out_strobe) begin
      got = '{out_bus_valid, out_bus_write, out_bus_address, out_bus_size, out_store_data,
              out_reg_write, out_reg_index, out_reg_value, out_flags_now, out_thumb_state,
              out_last, out_error};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%t unexpected transaction: %p", $time, got);
      end else begin
        exp = expected_q.pop_front();
        if (got !== exp) begin
          errors++;
          $display("%t mismatch expected %p actual %p", $time, exp, got);
        end
      end
    end
  end

  function automatic logic [15:0] rand_insn();
    logic [15:0] op;
    op = $urandom;
    case ($urandom_range(11))
      0: op[15:10] = 6'h11;
      1: op[15:11] = 5'h09;
      2: op[15:12] = 4'h5;
      3: op[15:13] = 3'h3;
      4: op[15:12] = 4'h8;
      5: op[15:12] = 4'h9;
      6: op[15:12] = 4'hA;
      7: op[15:8] = 8'hB0;
      8: begin
        op[15:12] = 4'hB;
        op[10:9] = 2'b10;
      end
      9: op[15:12] = 4'hC;
      default: ;
    endcase
    return op;
  endfunction

  task automatic test_directed();
    set_reg(4'd0, 32'hFFFF_FFFF);
    set_reg(4'd13, 32'h0000_1000);
    set_reg(4'd15, 32'h0000_0103);
    exec_op(16'h4101);
    send_item(REQ_RETURN, 0, 32'h1234, 0);
    exec_op(16'hDE00);
    exec_op(16'hBDFF);
    exec_op(16'h4800);
    send_item(REQ_BAD, 0, 0, 0);
    for (int i = 0; i < 9; i++) send_item(REQ_RETURN, 0, 32'h8000_8080 + i, 0);
    exec_op(16'hB5FF);
    exec_op(16'hB400);
    exec_op(16'hBC00);
    exec_op(16'hC8FF);
    drain_loads();
    exec_op(16'hC001);
    exec_op(16'h5E08);
    send_item(REQ_RETURN, 0, 32'h0000_8001, 0);
    exec_op(16'h5608);
    send_item(REQ_RETURN, 0, 32'h0000_0080, 0);
    exec_op(16'h9FFF);
    exec_op(16'hB0FF);
    exec_op(16'h4701);
    exec_op(16'h4687);
    exec_op(16'h4540);
    exec_op(16'hAFFF);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned stop;
    stop = n_items + n;
    while (n_items < stop) begin
      case ($urandom_range(9))
        0: set_reg($urandom, $urandom_range(1) ? $urandom : $urandom_range(64));
        1: send_item($urandom_range(9) == 0 ? REQ_BAD : REQ_RETURN,
                     $urandom, $urandom, $urandom);
        default: begin
          exec_op(rand_insn());
          if ($urandom_range(3) != 0) drain_loads();
        end
      endcase
    end
    drain_loads();
  endtask

  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    nzcv = '0;
    tbit = 1'b1;
    ring_cnt = 0;
    ring_head = 0;
    wb_armed = 1'b0;
    wb_reg = '0;
    wb_val = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    idle_pct = 7;
    test_random(130);
    idle_pct = 69;
    test_random(130);
    idle_pct = 0;
    test_random(140);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[thumb_load_store_unit.f]
sv/tlsu_pkg.sv
sv/tlsu_ctrl.sv
sv/tlsu_dp.sv
sv/thumb_load_store_unit.sv
sv/tlsu_checker.sv
tb/thumb_load_store_unit_test.sv
